FILE: src/ctw_pkg.sv
`default_nettype none
package ctw_pkg;

   // field widths
   localparam int PIXEL_W    = 8;
   localparam int CENSUS_W   = 48;
   localparam int CENTER_X_W = 10;
   localparam int ROW_W      = 12;

   // register widths
   localparam int WIN_SIZE_W = 3;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 12;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 12;

   // parameter defaults
   localparam int MAX_WINDOW_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 1024;

   // register reset values
   localparam int RST_WINDOW_SIZE  = 7;
   localparam int RST_IMAGE_WIDTH  = 640;
   localparam int RST_IMAGE_HEIGHT = 480;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WINDOW_SIZE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] pixel_value;
      logic                      is_flush;
   } req_type;

   typedef struct packed {
      logic [CENSUS_W-1:0]   census_bits;
      logic [CENTER_X_W-1:0] center_x;
      logic [ROW_W-1:0]      center_y;
      logic                  frame_last;
   } rsp_type;

endpackage
`default_nettype wire

FILE: src/census_transform_window.sv
// census transform over an odd square window, pixels in raster order
// throughput: one request per clock, pixel or flush, no bubbles, while rsp_ready keeps the pipeline moving
// path: the request stage addresses the banks, then s1 (bank read data), s2 (window) and the output register;
//   a pixel releases the descriptor r*W+r pixels behind it (one read per column bank per cycle while s1 moves)
// reset: positions, pending count and pipeline cleared, registers back to 7 / 640 / 480;
//   the line store is not cleared and holds nothing valid until written
`default_nettype none
module census_transform_window #(
   parameter int MAX_WINDOW = ctw_pkg::MAX_WINDOW_DEF,
   parameter int MAX_WIDTH  = ctw_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire ctw_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output ctw_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [ctw_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ctw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ctw_pkg::*;

   // geometry: N column banks, N row slots, row y lives in slot y mod N
   localparam int N        = MAX_WINDOW;
   localparam int R        = (N - 1) / 2;
   localparam int SIDE_MAX = 2 * R + 1;
   localparam int BW       = $clog2(N);
   localparam int NBD      = (MAX_WIDTH + N - 1) / N;
   localparam int AW       = (NBD > 1) ? $clog2(NBD) : 1;
   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int WX       = (WW > IMG_W_W) ? WW : IMG_W_W;
   localparam int RW       = $clog2(R + 1);
   localparam int LAG_MAX  = R * MAX_WIDTH + R;
   localparam int PW       = $clog2(LAG_MAX + 2);

   // reset values after rounding and clamping
   localparam int WS_RST   = RST_WINDOW_SIZE | 1;
   localparam int SIDE_RST = (WS_RST > SIDE_MAX) ? SIDE_MAX : WS_RST;
   localparam int R_RST    = SIDE_RST / 2;
   localparam int W_RST    = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
   localparam int LAG_RST  = R_RST * W_RST + R_RST;

   // a raster position, kept together with its bank / bank address / row slot
   typedef struct packed {
      logic [CW-1:0]    col;
      logic [ROW_W-1:0] row;
      logic [BW-1:0]    b;
      logic [AW-1:0]    q;
      logic [BW-1:0]    slot;
   } pos_type;

   function automatic pos_type pos_next(input pos_type p, input logic [WW-1:0] w,
                                        input logic [ROW_W-1:0] h);
      pos_type n;
      n = p;
      if ((WW+1)'(p.col) + (WW+1)'(1) >= (WW+1)'(w)) begin
         n.col = '0;
         n.b   = '0;
         n.q   = '0;
         if ((ROW_W+1)'(p.row) + (ROW_W+1)'(1) >= (ROW_W+1)'(h)) begin
            n.row  = '0;
            n.slot = '0;
         end else begin
            n.row  = p.row + ROW_W'(1);
            n.slot = (p.slot == BW'(N - 1)) ? '0 : p.slot + BW'(1);
         end
      end else begin
         n.col = p.col + CW'(1);
         if (p.b == BW'(N - 1)) begin
            n.b = '0;
            n.q = p.q + AW'(1);
         end else begin
            n.b = p.b + BW'(1);
         end
      end
      return n;
   endfunction

   // base plus a constant offset, modulo N
   function automatic logic [BW-1:0] ring_idx(input logic [BW-1:0] base,
                                              input logic [BW+1:0] off);
      logic [BW+1:0] s;
      s = {2'b00, base} + off;
      if (s >= (BW+2)'(N)) s = s - (BW+2)'(N);
      if (s >= (BW+2)'(N)) s = s - (BW+2)'(N);
      return s[BW-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // configuration, kept in its effective form (odd side, clamped sizes)
   // ---------------------------------------------------------------------
   logic [RW-1:0]    r_ff, r_in;
   logic [WW-1:0]    width_ff, width_in;
   logic [ROW_W-1:0] height_ff, height_in;
   logic [PW-1:0]    lag_ff, lag_in;

   logic [WIN_SIZE_W-1:0] ws;
   logic [RW-1:0]         new_r;
   logic [WX-1:0]         wraw;
   logic [WW-1:0]         new_w;
   logic [IMG_H_W-1:0]    new_h;

   always_comb begin
      // even sides round up by setting the low bit
      ws = csr_wdata[WIN_SIZE_W-1:0] | WIN_SIZE_W'(1);
      if (ws > WIN_SIZE_W'(SIDE_MAX)) ws = WIN_SIZE_W'(SIDE_MAX);
      new_r = RW'(ws >> 1);

      wraw = WX'(csr_wdata[IMG_W_W-1:0]);
      if (wraw == '0) wraw = WX'(1);
      else if (wraw > WX'(MAX_WIDTH)) wraw = WX'(MAX_WIDTH);
      new_w = WW'(wraw);

      new_h = csr_wdata[IMG_H_W-1:0];
      if (new_h == '0) new_h = IMG_H_W'(1);

      r_in      = r_ff;
      width_in  = width_ff;
      height_in = height_ff;
      lag_in    = lag_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_WINDOW_SIZE: begin
               r_in   = new_r;
               lag_in = PW'(PW'(new_r) * PW'(width_ff) + PW'(new_r));
            end
            CSR_IMAGE_WIDTH: begin
               width_in = new_w;
               lag_in   = PW'(PW'(r_ff) * PW'(new_w) + PW'(r_ff));
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = ROW_W'(new_h);
            end
            default: begin
               // unused index, write ignored
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // pipeline flow: out <- s2 (window) <- s1 (bank read data) <- request
   // each stage moves when the one after it moves or is empty
   // ---------------------------------------------------------------------
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic out_v_ff, out_v_in;
   logic out_en, s2_en, s1_en;

   assign out_en    = !out_v_ff || rsp_ready;
   assign s2_en     = out_en || !s2_v_ff;
   assign s1_en     = s2_en || !s1_v_ff;
   assign req_ready = s1_en;

   // ---------------------------------------------------------------------
   // request stage: write the pixel, decide whether a descriptor leaves,
   // and address every column bank for the window around the output position
   // ---------------------------------------------------------------------
   pos_type       in_pos_ff, in_pos_in;
   pos_type       out_pos_ff, out_pos_in;
   logic [PW-1:0] pending_ff, pending_in;

   logic accept;
   logic is_pix;
   logic emit;
   logic x_lo, x_hi, y_lo, y_hi;
   logic interior;
   logic last;
   logic [N-1:0]  wr_en;
   logic [AW-1:0] rd_addr [N];

   assign accept = req_valid && req_ready;
   assign is_pix = !req_data.is_flush;

   always_comb begin
      // a pixel releases a descriptor once more than lag pixels wait;
      // a flush releases one whenever anything waits
      if (is_pix) emit = accept && ((pending_ff + PW'(1)) > lag_ff);
      else        emit = accept && (pending_ff != '0);

      pending_in = pending_ff;
      if (accept) begin
         pending_in = pending_ff + PW'(is_pix) - PW'(emit);
      end

      in_pos_in  = (accept && is_pix) ? pos_next(in_pos_ff, width_ff, height_ff) : in_pos_ff;
      out_pos_in = emit ? pos_next(out_pos_ff, width_ff, height_ff) : out_pos_ff;
   end

   // edge test: centers closer than r to any border give an all-zero descriptor
   always_comb begin
      x_lo = (WW+1)'(out_pos_ff.col) >= (WW+1)'(r_ff);
      x_hi = ((WW+1)'(out_pos_ff.col) + (WW+1)'(r_ff)) < (WW+1)'(width_ff);
      y_lo = (ROW_W+1)'(out_pos_ff.row) >= (ROW_W+1)'(r_ff);
      y_hi = ((ROW_W+1)'(out_pos_ff.row) + (ROW_W+1)'(r_ff)) < (ROW_W+1)'(height_ff);
      interior = x_lo && x_hi && y_lo && y_hi;
      last = (((WW+1)'(out_pos_ff.col) + (WW+1)'(1)) == (WW+1)'(width_ff)) &&
             (((ROW_W+1)'(out_pos_ff.row) + (ROW_W+1)'(1)) == (ROW_W+1)'(height_ff));
   end

   // bank k holds the window column whose offset from the center is k - b,
   // folded into -R..R; folding moves one bank address back or forward
   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (BW'(k) >= out_pos_ff.b) begin
            if ((BW'(k) - out_pos_ff.b) > BW'(R)) rd_addr[k] = out_pos_ff.q - AW'(1);
            else                                  rd_addr[k] = out_pos_ff.q;
         end else if ((out_pos_ff.b - BW'(k)) > BW'(R)) begin
            rd_addr[k] = out_pos_ff.q + AW'(1);
         end else begin
            rd_addr[k] = out_pos_ff.q;
         end
         wr_en[k] = accept && is_pix && (in_pos_ff.b == BW'(k));
      end
   end

   // column banks; a write in the reading cycle is forwarded inside the bank
   logic [N-1:0][PIXEL_W-1:0] bank_word [N];

   for (genvar k = 0; k < N; k++) begin : g_bank
      ctw_bank #(
         .SLOTS (N),
         .DEPTH (NBD)
      ) u_bank (
         .clock   (clock),
         .reset   (reset),
         .rd_en   (s1_en),
         .rd_addr (rd_addr[k]),
         .wr_en   (wr_en[k]),
         .wr_addr (in_pos_ff.q),
         .wr_slot (in_pos_ff.slot),
         .wr_data (req_data.pixel_value),
         .rd_word (bank_word[k])
      );
   end

   // ---------------------------------------------------------------------
   // s1: descriptor context alongside the bank read data
   // ---------------------------------------------------------------------
   logic [CW-1:0]    s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_last_ff;
   logic             s1_int_ff;
   logic [RW-1:0]    s1_r_ff;
   logic [BW-1:0]    s1_b_ff;
   logic [BW-1:0]    s1_slot_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_col_ff  <= out_pos_ff.col;
         s1_row_ff  <= out_pos_ff.row;
         s1_last_ff <= last;
         s1_int_ff  <= interior;
         s1_r_ff    <= r_ff;
         s1_b_ff    <= out_pos_ff.b;
         s1_slot_ff <= out_pos_ff.slot;
      end
   end

   // rotate banks into window columns and slots into window rows
   logic [BW-1:0]                bidx [N];
   logic [BW-1:0]                sidx [N];
   logic [N-1:0][PIXEL_W-1:0]    colw [N];
   logic signed [PIXEL_W-1:0]    win_in [N][N];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         bidx[i] = ring_idx(s1_b_ff, (BW+2)'(i + N - R));
         sidx[i] = ring_idx(s1_slot_ff, (BW+2)'(i + N - R));
      end
      for (int i = 0; i < N; i++) begin
         colw[i] = bank_word[bidx[i]];
      end
      for (int j = 0; j < N; j++) begin
         for (int i = 0; i < N; i++) begin
            win_in[j][i] = colw[i][sidx[j]];
         end
      end
   end

   // ---------------------------------------------------------------------
   // s2: window registers, row j / column i, center at R,R
   // ---------------------------------------------------------------------
   logic signed [PIXEL_W-1:0] win_ff [N][N];
   logic [CW-1:0]             s2_col_ff;
   logic [ROW_W-1:0]          s2_row_ff;
   logic                      s2_last_ff;
   logic                      s2_int_ff;
   logic [RW-1:0]             s2_r_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         win_ff     <= win_in;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_last_ff <= s1_last_ff;
         s2_int_ff  <= s1_int_ff;
         s2_r_ff    <= s1_r_ff;
      end
   end

   // all neighbor compares in parallel, signed
   logic cmp [N][N];

   always_comb begin
      for (int j = 0; j < N; j++) begin
         for (int i = 0; i < N; i++) begin
            cmp[j][i] = win_ff[j][i] >= win_ff[R][R];
         end
      end
   end

   // one packing per radius: window raster order with the center skipped
   wire [CENSUS_W-1:0] pack [R+1];

   for (genvar rr = 0; rr <= R; rr++) begin : g_rad
      localparam int SIDE  = 2 * rr + 1;
      localparam int NBITS = SIDE * SIDE - 1;
      for (genvar j = 0; j < SIDE; j++) begin : g_row
         for (genvar i = 0; i < SIDE; i++) begin : g_col
            localparam int POS = j * SIDE + i;
            if (POS < NBITS / 2) begin : g_before
               assign pack[rr][POS] = cmp[R - rr + j][R - rr + i];
            end else if (POS > NBITS / 2) begin : g_after
               assign pack[rr][POS - 1] = cmp[R - rr + j][R - rr + i];
            end
         end
      end
      if (NBITS < CENSUS_W) begin : g_pad
         assign pack[rr][CENSUS_W-1:NBITS] = '0;
      end
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_ff.census_bits <= s2_int_ff ? pack[s2_r_ff] : '0;
         rsp_ff.center_x    <= CENTER_X_W'(s2_col_ff);
         rsp_ff.center_y    <= s2_row_ff;
         rsp_ff.frame_last  <= s2_last_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      s1_v_in  = s1_en  ? emit     : s1_v_ff;
      s2_v_in  = s2_en  ? s1_v_ff  : s2_v_ff;
      out_v_in = out_en ? s2_v_ff  : out_v_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff       <= RW'(R_RST);
         width_ff   <= WW'(W_RST);
         height_ff  <= ROW_W'(RST_IMAGE_HEIGHT);
         lag_ff     <= PW'(LAG_RST);
         pending_ff <= '0;
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         r_ff       <= r_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         lag_ff     <= lag_in;
         pending_ff <= pending_in;
         in_pos_ff  <= in_pos_in;
         out_pos_ff <= out_pos_in;
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s2_v_in;
         out_v_ff   <= out_v_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/ctw_bank.sv
`default_nettype none
module ctw_bank #(
   parameter int SLOTS = 7,
   parameter int DEPTH = 147,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   rd_en,
   input  wire logic [AW-1:0]                          rd_addr,
   input  wire logic                                   wr_en,
   input  wire logic [AW-1:0]                          wr_addr,
   input  wire logic [SW-1:0]                          wr_slot,
   input  wire logic [ctw_pkg::PIXEL_W-1:0]            wr_data,
   output logic [SLOTS-1:0][ctw_pkg::PIXEL_W-1:0]      rd_word
);
   import ctw_pkg::*;

   // one column word holds that column of every buffered row
   logic [SLOTS-1:0][PIXEL_W-1:0] mem [DEPTH];
   logic [SLOTS-1:0][PIXEL_W-1:0] rd_ff;
   logic                          fwd_ff;
   logic [SW-1:0]                 fwd_slot_ff;
   logic [PIXEL_W-1:0]            fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][wr_slot] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         fwd_slot_ff <= wr_slot;
         fwd_data_ff <= wr_data;
      end
   end

   // same-cycle write to the read address wins
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_comb begin
      rd_word = rd_ff;
      if (fwd_ff) begin
         rd_word[fwd_slot_ff] = fwd_data_ff;
      end
   end

endmodule
`default_nettype wire
